// ===== rtl/gasa_pkg.sv =====
package gasa_pkg;

  localparam int MAX_SHELVES = 32;
  localparam int CNT_W       = $clog2(MAX_SHELVES + 1);

  localparam int GW_W    = 10;
  localparam int PAD_W   = GW_W + 1;
  localparam int COORD_W = 16;
  localparam int ATLAS_W = 13;
  localparam int IDX_W   = 5;

  localparam logic [ATLAS_W-1:0] ATLAS_RESET = 13'd512;

  // Floor division by ten via reciprocal multiply; exact for values below 16384.
  localparam int GROW_IN_W  = 14;
  localparam int GROW_MUL   = 6554;
  localparam int GROW_SHIFT = 16;
  localparam int PROD_W     = 28;

  typedef struct packed {
    logic [PAD_W-1:0] pw;
    logic [PAD_W-1:0] ph;
    logic [GW_W-1:0]  h;
    logic [PAD_W-1:0] grow;
  } req_t;

  typedef struct packed {
    logic shift;
    logic clear;
    logic open;
    logic upd;
    logic last;
  } cmd_t;

  typedef struct packed {
    logic               fit;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } cell_stat_t;

  function automatic logic [COORD_W-1:0] sat16(input logic [COORD_W:0] v);
    return v[COORD_W] ? {COORD_W{1'b1}} : v[COORD_W-1:0];
  endfunction

endpackage

// ===== rtl/gasa_cell.sv =====
module gasa_cell (
  input  logic                            clk,
  input  logic                            rst_n,
  input  gasa_pkg::cmd_t                  cmd,
  input  gasa_pkg::req_t                  req,
  input  logic [gasa_pkg::ATLAS_W-1:0]    atlas,
  input  logic                            tok_in,
  input  logic [gasa_pkg::COORD_W-1:0]    prev_in,
  output logic                            tok_out,
  output logic [gasa_pkg::COORD_W-1:0]    bot_out,
  output gasa_pkg::cell_stat_t            stat
);

  logic                           tok_r, tok_nxt;
  logic [gasa_pkg::COORD_W-1:0]   prev_r, prev_nxt;
  logic [gasa_pkg::COORD_W-1:0]   bottom_r, bottom_nxt;
  logic [gasa_pkg::COORD_W-1:0]   right_r, right_nxt;
  logic [gasa_pkg::COORD_W:0]     rh;
  logic [gasa_pkg::COORD_W:0]     ph_x;
  logic                           fit_c;
  logic [gasa_pkg::COORD_W-1:0]   new_bot;
  logic [gasa_pkg::COORD_W-1:0]   base_bot;
  logic [gasa_pkg::COORD_W-1:0]   base_right;
  logic [gasa_pkg::COORD_W:0]     h1;
  logic [gasa_pkg::COORD_W-1:0]   y_c;
  logic [gasa_pkg::COORD_W-1:0]   x_c;

  always_comb begin
    ph_x    = (gasa_pkg::COORD_W+1)'(req.ph);
    rh      = (bottom_r >= prev_r) ? {1'b0, bottom_r - prev_r} : '0;
    fit_c   = (ph_x <= rh) && (ph_x >= (rh >> 1)) &&
              (({1'b0, right_r} + (gasa_pkg::COORD_W+1)'(req.pw)) <
               (gasa_pkg::COORD_W+1)'(atlas));
    new_bot = gasa_pkg::sat16({1'b0, prev_r} + (gasa_pkg::COORD_W+1)'(req.grow));

    base_bot   = cmd.last ? new_bot : bottom_r;
    base_right = cmd.last ? '0 : right_r;
    h1         = (gasa_pkg::COORD_W+1)'(req.h) + (gasa_pkg::COORD_W+1)'(1);
    y_c        = ({1'b0, base_bot} >= h1) ?
                 gasa_pkg::COORD_W'({1'b0, base_bot} - h1) : '0;
    x_c        = gasa_pkg::sat16({1'b0, base_right} + (gasa_pkg::COORD_W+1)'(1));

    stat.fit = tok_r & fit_c;
    stat.x   = tok_r ? x_c : '0;
    stat.y   = tok_r ? y_c : '0;
  end

  always_comb begin
    tok_nxt    = tok_r;
    prev_nxt   = prev_r;
    bottom_nxt = bottom_r;
    right_nxt  = right_r;
    if (cmd.shift) begin
      tok_nxt  = tok_in;
      prev_nxt = prev_in;
    end else if (cmd.clear) begin
      tok_nxt = 1'b0;
    end
    if (tok_r && (cmd.open || cmd.upd)) begin
      right_nxt = gasa_pkg::sat16({1'b0, base_right} + (gasa_pkg::COORD_W+1)'(req.pw));
    end
    if (tok_r && cmd.open) begin
      bottom_nxt = new_bot;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= 1'b0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prev_r   <= prev_nxt;
    bottom_r <= bottom_nxt;
    right_r  <= right_nxt;
  end

  assign tok_out = tok_r;
  assign bot_out = bottom_r;

endmodule

// ===== rtl/glyph_atlas_shelf_allocator_unit.sv =====
// Shelf-packing allocator for a glyph atlas. One item is taken at a time: the
// item is registered at acceptance, then a token walks the chain of shelf cells
// one shelf per cycle until a shelf fits or the open shelves run out. The result
// is written to the output register when the scan ends, once no earlier result
// still waits under out_stall. The next item is accepted in the cycle after the
// result has been written, so no new item is taken while one is still in the
// scan.
module glyph_atlas_shelf_allocator_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [gasa_pkg::ATLAS_W-1:0]      cfg_wr_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [gasa_pkg::GW_W-1:0]         in_glyph_width,
  input  logic [gasa_pkg::GW_W-1:0]         in_glyph_height,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [gasa_pkg::COORD_W-1:0]      out_place_x,
  output logic [gasa_pkg::COORD_W-1:0]      out_place_y,
  output logic [gasa_pkg::IDX_W-1:0]        out_shelf_index,
  output logic                              out_no_room
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  logic                             state_r, state_nxt;
  logic [gasa_pkg::ATLAS_W-1:0]     atlas_r;
  logic [gasa_pkg::CNT_W-1:0]       count_r, count_nxt;
  logic [gasa_pkg::CNT_W-1:0]       idx_r, idx_nxt;
  gasa_pkg::req_t                   req_r, req_nxt;

  logic                             out_valid_r, out_valid_nxt;
  logic [gasa_pkg::COORD_W-1:0]     out_x_r, out_x_nxt;
  logic [gasa_pkg::COORD_W-1:0]     out_y_r, out_y_nxt;
  logic [gasa_pkg::IDX_W-1:0]       out_idx_r, out_idx_nxt;
  logic                             out_nr_r, out_nr_nxt;

  logic                             in_fire;
  logic                             end_c;
  logic                             full_c;
  logic                             fit_any;
  logic                             done_c;
  logic                             commit;
  logic                             step;
  logic [gasa_pkg::PAD_W-1:0]       ph_in;
  logic [gasa_pkg::GROW_IN_W-1:0]   ph11;
  logic [gasa_pkg::PROD_W-1:0]      grow_prod;
  logic [gasa_pkg::COORD_W-1:0]     x_or;
  logic [gasa_pkg::COORD_W-1:0]     y_or;
  logic                             fit_or;
  gasa_pkg::cmd_t                   cmd;

  logic [gasa_pkg::MAX_SHELVES-1:0] tok_q;
  logic [gasa_pkg::COORD_W-1:0]     bot_q  [gasa_pkg::MAX_SHELVES];
  gasa_pkg::cell_stat_t             stat_q [gasa_pkg::MAX_SHELVES];

  assign in_stall = (state_r != ST_IDLE);
  assign in_fire  = in_valid && !in_stall;

  assign end_c   = (idx_r == count_r);
  assign full_c  = (count_r == gasa_pkg::CNT_W'(gasa_pkg::MAX_SHELVES));
  assign fit_any = fit_or && !end_c;
  assign done_c  = (state_r == ST_SCAN) && (end_c || fit_any);
  assign commit  = done_c && (!out_valid_r || !out_stall);
  assign step    = (state_r == ST_SCAN) && !end_c && !fit_any;

  always_comb begin
    cmd.shift = in_fire || step;
    cmd.clear = commit;
    cmd.open  = commit && end_c && !full_c;
    cmd.upd   = commit && !end_c;
    cmd.last  = end_c;
  end

  always_comb begin
    fit_or = 1'b0;
    x_or   = '0;
    y_or   = '0;
    for (int i = 0; i < gasa_pkg::MAX_SHELVES; i++) begin
      fit_or = fit_or | stat_q[i].fit;
      x_or   = x_or | stat_q[i].x;
      y_or   = y_or | stat_q[i].y;
    end
  end

  genvar g;
  generate
    for (g = 0; g < gasa_pkg::MAX_SHELVES; g++) begin : g_cell
      if (g == 0) begin : g_head
        gasa_cell u_cell (
          .clk     (clk),
          .rst_n   (rst_n),
          .cmd     (cmd),
          .req     (req_r),
          .atlas   (atlas_r),
          .tok_in  (in_fire),
          .prev_in ('0),
          .tok_out (tok_q[g]),
          .bot_out (bot_q[g]),
          .stat    (stat_q[g])
        );
      end else begin : g_body
        gasa_cell u_cell (
          .clk     (clk),
          .rst_n   (rst_n),
          .cmd     (cmd),
          .req     (req_r),
          .atlas   (atlas_r),
          .tok_in  (tok_q[g-1]),
          .prev_in (bot_q[g-1]),
          .tok_out (tok_q[g]),
          .bot_out (bot_q[g]),
          .stat    (stat_q[g])
        );
      end
    end
  endgenerate

  always_comb begin
    ph_in     = gasa_pkg::PAD_W'(in_glyph_height) + gasa_pkg::PAD_W'(2);
    ph11      = (gasa_pkg::GROW_IN_W'(ph_in) << 3) + (gasa_pkg::GROW_IN_W'(ph_in) << 1) +
                gasa_pkg::GROW_IN_W'(ph_in);
    grow_prod = gasa_pkg::PROD_W'(ph11) * gasa_pkg::PROD_W'(gasa_pkg::GROW_MUL);
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    req_nxt       = req_r;
    out_valid_nxt = out_valid_r;
    out_x_nxt     = out_x_r;
    out_y_nxt     = out_y_r;
    out_idx_nxt   = out_idx_r;
    out_nr_nxt    = out_nr_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          req_nxt.pw   = gasa_pkg::PAD_W'(in_glyph_width) + gasa_pkg::PAD_W'(2);
          req_nxt.ph   = ph_in;
          req_nxt.h    = in_glyph_height;
          req_nxt.grow = grow_prod[gasa_pkg::GROW_SHIFT +: gasa_pkg::PAD_W];
          idx_nxt      = '0;
          state_nxt    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (step) begin
          idx_nxt = idx_r + gasa_pkg::CNT_W'(1);
        end
        if (commit) begin
          out_valid_nxt = 1'b1;
          out_nr_nxt    = end_c && full_c;
          out_x_nxt     = x_or;
          out_y_nxt     = y_or;
          out_idx_nxt   = (end_c && full_c) ? '0 : gasa_pkg::IDX_W'(idx_r);
          if (cmd.open) begin
            count_nxt = count_r + gasa_pkg::CNT_W'(1);
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
      atlas_r     <= gasa_pkg::ATLAS_RESET;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        atlas_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    req_r     <= req_nxt;
    out_x_r   <= out_x_nxt;
    out_y_r   <= out_y_nxt;
    out_idx_r <= out_idx_nxt;
    out_nr_r  <= out_nr_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_place_x     = out_x_r;
  assign out_place_y     = out_y_r;
  assign out_shelf_index = out_idx_r;
  assign out_no_room     = out_nr_r;

  a_tok_onehot0: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(tok_q))
    else $error("more than one shelf cell holds the scan token");

  a_tok_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (tok_q == '0))
    else $error("scan token left in the chain while idle");

  a_tok_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN && idx_r < gasa_pkg::CNT_W'(gasa_pkg::MAX_SHELVES)) |->
    $onehot(tok_q))
    else $error("scan token lost during a scan");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r <= gasa_pkg::CNT_W'(gasa_pkg::MAX_SHELVES)) && (idx_r <= count_r))
    else $error("shelf count or scan index out of range");

  a_commit_idle: assert property (@(posedge clk) disable iff (!rst_n)
    commit |=> (state_r == ST_IDLE) && out_valid_r)
    else $error("commit did not produce a result and return to idle");

endmodule
